FILE: src/modbus_rtu_frame_checker_macros.svh
// Assertion macros for the Modbus RTU frame checker verification files.
`ifndef MODBUS_RTU_FRAME_CHECKER_MACROS_SVH
`define MODBUS_RTU_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MRTU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame checker property violated");

// Next-cycle implication, disabled while reset is high.
`define MRTU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame checker property violated");

`endif

FILE: src/mrtu_pkg.sv
// Types, constants and the CRC byte update for the Modbus RTU frame checker.
package mrtu_pkg;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_LENGTH = 2'd1,
      STATUS_CRC    = 2'd2
   } mrtu_status_type;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [8:0]  COUNT_SAT = 9'd511;
   // Byte index from which a PDU byte leaves the delay line.
   localparam logic [8:0]  PDU_START = 9'd3;
   // Address plus two CRC bytes.
   localparam logic [8:0]  FRAME_OVERHEAD = 9'd3;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_frame;
   } mrtu_req_type;

   typedef struct packed {
      logic [7:0]      pdu_byte;
      logic            byte_valid;
      logic            frame_done;
      mrtu_status_type frame_status;
      logic [7:0]      slave_address;
      logic [7:0]      pdu_length;
   } mrtu_rsp_type;

   // Reflected CRC-16 update over one byte, least significant bit first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

FILE: src/mrtu_stream_if.sv
// Valid/ready stream channel carrying one payload item per request.
interface mrtu_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/modbus_rtu_frame_checker.sv
// Latency: a result is presented in the cycle after its request is accepted.
// Throughput: one byte per cycle while rsp_chan does not stall; the limit is the
// unrolled CRC byte update feeding the result register.
// A result waiting on rsp_chan does not block the next request when it is taken.
// Synchronous active-high reset returns the CRC, count, address, delay line
// and result-valid flag to their idle values.
module modbus_rtu_frame_checker #(
   parameter int MAX_FRAME_BYTES = 256,
   parameter int MIN_FRAME_BYTES = 4
) (
   input logic           clock,
   input logic           reset,
   mrtu_stream_if.sink   req_chan,
   mrtu_stream_if.source rsp_chan
);

   localparam logic [8:0] MAX_COUNT = 9'(MAX_FRAME_BYTES);
   localparam logic [8:0] MIN_COUNT = 9'(MIN_FRAME_BYTES);

   logic [15:0]          crc_ff, crc_in;
   logic [8:0]           count_ff, count_in;
   logic [7:0]           addr_ff, addr_in;
   logic [7:0]           dly0_ff, dly0_in;
   logic [7:0]           dly1_ff, dly1_in;
   logic                 out_valid_ff;
   mrtu_pkg::mrtu_rsp_type out_ff, out_in;

   mrtu_pkg::mrtu_req_type req;
   logic                 accept;
   logic                 produce;
   logic                 pdu_valid;
   logic [15:0]          crc_next;
   logic [8:0]           count_next;
   logic [7:0]           addr_sel;
   logic                 length_bad;

   assign req             = req_chan.payload;
   assign req_chan.ready  = !out_valid_ff || rsp_chan.ready;
   assign accept          = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   always_comb begin
      addr_sel   = (count_ff == 9'd0) ? req.rx_byte : addr_ff;
      crc_next   = mrtu_pkg::crc_byte(crc_ff, req.rx_byte);
      pdu_valid  = count_ff >= mrtu_pkg::PDU_START;
      count_next = (count_ff == mrtu_pkg::COUNT_SAT) ? count_ff : count_ff + 9'd1;
      length_bad = (count_next > MAX_COUNT) || (count_next < MIN_COUNT);
      produce    = pdu_valid || req.end_of_frame;

      out_in               = '0;
      out_in.frame_status  = mrtu_pkg::STATUS_OK;
      out_in.byte_valid    = pdu_valid;
      out_in.pdu_byte      = pdu_valid ? dly1_ff : 8'd0;
      if (req.end_of_frame) begin
         out_in.frame_done    = 1'b1;
         out_in.slave_address = addr_sel;
         if (length_bad) begin
            out_in.frame_status = mrtu_pkg::STATUS_LENGTH;
         end else begin
            out_in.pdu_length   = 8'(count_next - mrtu_pkg::FRAME_OVERHEAD);
            out_in.frame_status = (crc_next == 16'd0) ? mrtu_pkg::STATUS_OK
                                                      : mrtu_pkg::STATUS_CRC;
         end
      end

      // The last byte of a frame returns the CRC, count, address and delay line to idle.
      if (req.end_of_frame) begin
         crc_in   = mrtu_pkg::CRC_INIT;
         count_in = 9'd0;
         addr_in  = 8'd0;
         dly0_in  = 8'd0;
         dly1_in  = 8'd0;
      end else begin
         crc_in   = crc_next;
         count_in = count_next;
         addr_in  = addr_sel;
         dly0_in  = req.rx_byte;
         dly1_in  = dly0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= mrtu_pkg::CRC_INIT;
         count_ff     <= 9'd0;
         addr_ff      <= 8'd0;
         dly0_ff      <= 8'd0;
         dly1_ff      <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            crc_ff   <= crc_in;
            count_ff <= count_in;
            addr_ff  <= addr_in;
            dly0_ff  <= dly0_in;
            dly1_ff  <= dly1_in;
         end
         if (accept && produce) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && produce) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: src/mrtu_checker.sv
// Port-level assertions for the Modbus RTU frame checker, with its bind.
`include "modbus_rtu_frame_checker_macros.svh"

module mrtu_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input mrtu_pkg::mrtu_rsp_type rsp_payload
);

   // A stalled result keeps its contents.
   `MRTU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // Every result carries either a PDU byte or a frame report.
   `MRTU_ASSERT_IMPLY(a_rsp_not_empty, clock, reset, rsp_valid, rsp_payload.byte_valid || rsp_payload.frame_done)

   // Frame report fields stay zero on results that do not close a frame.
   `MRTU_ASSERT_IMPLY(a_report_zero, clock, reset, rsp_valid && !rsp_payload.frame_done, rsp_payload.frame_status == mrtu_pkg::STATUS_OK && rsp_payload.slave_address == 8'd0 && rsp_payload.pdu_length == 8'd0)

   // A good frame always holds at least one PDU byte.
   `MRTU_ASSERT_IMPLY(a_ok_has_pdu, clock, reset, rsp_valid && rsp_payload.frame_done && rsp_payload.frame_status == mrtu_pkg::STATUS_OK, rsp_payload.pdu_length != 8'd0)

endmodule

bind modbus_rtu_frame_checker mrtu_checker u_mrtu_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
